### sv/dfa_keyword_lexer_assert.svh
// Assertion macros for the DFA keyword lexer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DFA_KEYWORD_LEXER_ASSERT_SVH
`define DFA_KEYWORD_LEXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DLX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dfa_keyword_lexer: same-cycle check failed");
`define DLX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dfa_keyword_lexer: next-cycle check failed");
`else
`define DLX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLX_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/dlx_pkg.sv
// Package for the DFA keyword lexer: constants, result type, transition and kind tables.
// No dependencies.
`timescale 1ns / 1ps

package dlx_pkg;

	localparam logic [7:0] NOEDGE      = 8'hFF;
	localparam logic [7:0] START_STATE = 8'd0;
	localparam logic [6:0] KIND_ERROR  = 7'd0;
	localparam logic [6:0] KIND_IGN    = 7'h7F;
	localparam logic [7:0] LEN_LIM     = 8'd255;
	localparam logic [15:0] POS_LIM    = 16'hFFFF;
	localparam logic [7:0] CHAR_NL     = 8'h0A;

	typedef struct packed {
		logic [6:0]  kind;
		logic [15:0] row;
		logic [15:0] col;
		logic [7:0]  len;
		logic        at_end;
		logic        done;
	} res_t;

	// letter that moves a keyword state s on to s+1, 0 if none
	function automatic logic [7:0] chain_letter(input logic [7:0] s);
		logic [7:0] l;
		l = 8'd0;
		case (s)
			8'd19: l = "O";  8'd20: l = "R";  8'd22: l = "E";  8'd23: l = "G";
			8'd24: l = "I";  8'd25: l = "N";  8'd42: l = "D";  8'd44: l = "H";
			8'd46: l = "X";  8'd27: l = "N";  8'd28: l = "D";  8'd56: l = "E";
			8'd57: l = "V";  8'd58: l = "A";  8'd59: l = "T";  8'd60: l = "O";
			8'd61: l = "R";  8'd30: l = "O";  8'd31: l = "N";  8'd32: l = "S";
			8'd33: l = "O";  8'd34: l = "L";  8'd35: l = "E";  8'd48: l = "L";
			8'd49: l = "L";  8'd51: l = "R";  8'd52: l = "C";  8'd53: l = "L";
			8'd54: l = "E";  8'd63: l = "E";  8'd64: l = "E";  8'd65: l = "P";
			8'd66: l = "S";  8'd67: l = "E";  8'd68: l = "A";  8'd70: l = "U";
			8'd71: l = "M";  8'd72: l = "A";  8'd73: l = "N";  8'd75: l = "N";
			8'd77: l = "L";  8'd78: l = "A";  8'd79: l = "C";  8'd80: l = "E";
			8'd82: l = "I";  8'd83: l = "T";  8'd84: l = "U";  8'd86: l = "E";
			8'd87: l = "C";  8'd88: l = "T";  8'd89: l = "I";  8'd90: l = "O";
			8'd91: l = "N";  8'd93: l = "I";  8'd94: l = "N";  8'd95: l = "E";
			8'd97: l = "O";  8'd98: l = "N";  8'd99: l = "I";  8'd100: l = "T";
			8'd101: l = "O"; 8'd102: l = "R"; 8'd103: l = "I"; 8'd104: l = "N";
			8'd105: l = "G"; 8'd107: l = "R"; 8'd108: l = "E"; 8'd110: l = "E";
			8'd111: l = "D"; 8'd113: l = "A"; 8'd114: l = "T"; 8'd115: l = "H";
			8'd117: l = "A"; 8'd118: l = "T"; 8'd119: l = "F"; 8'd120: l = "O";
			8'd121: l = "R"; 8'd122: l = "M"; 8'd124: l = "L"; 8'd125: l = "Y";
			8'd127: l = "O"; 8'd128: l = "N"; 8'd130: l = "I"; 8'd131: l = "N";
			8'd132: l = "E"; 8'd134: l = "N"; 8'd135: l = "T"; 8'd137: l = "M";
			8'd138: l = "P"; 8'd140: l = "O"; 8'd141: l = "C"; 8'd142: l = "E";
			8'd143: l = "S"; 8'd144: l = "S"; 8'd145: l = "I"; 8'd146: l = "N";
			8'd147: l = "G"; 8'd149: l = "I"; 8'd150: l = "V"; 8'd151: l = "E";
			8'd152: l = "R"; 8'd154: l = "E"; 8'd155: l = "R"; 8'd157: l = "C";
			8'd158: l = "O"; 8'd159: l = "V"; 8'd160: l = "E"; 8'd161: l = "R";
			8'd162: l = "Y"; 8'd164: l = "U"; 8'd165: l = "R"; 8'd166: l = "N";
			8'd168: l = "T"; 8'd169: l = "O"; 8'd170: l = "R"; 8'd171: l = "A";
			8'd172: l = "G"; 8'd173: l = "E"; 8'd175: l = "I"; 8'd176: l = "P";
			8'd178: l = "R"; 8'd179: l = "F"; 8'd180: l = "A"; 8'd181: l = "C";
			8'd182: l = "E"; 8'd184: l = "A"; 8'd185: l = "F"; 8'd186: l = "T";
			8'd188: l = "O"; 8'd189: l = "I"; 8'd190: l = "L"; 8'd191: l = "P";
			8'd192: l = "I"; 8'd193: l = "T"; 8'd195: l = "U"; 8'd196: l = "N";
			8'd197: l = "N"; 8'd198: l = "E"; 8'd199: l = "L"; 8'd201: l = "N";
			8'd202: l = "D"; 8'd203: l = "E"; 8'd204: l = "R"; 8'd205: l = "G";
			8'd206: l = "R"; 8'd207: l = "O"; 8'd208: l = "U"; 8'd209: l = "N";
			8'd210: l = "D"; 8'd212: l = "A"; 8'd213: l = "S"; 8'd214: l = "H";
			8'd215: l = "I"; 8'd216: l = "N"; 8'd217: l = "G"; 8'd219: l = "L";
			8'd220: l = "L";
			default: l = 8'd0;
		endcase
		return l;
	endfunction

	// keyword edges that jump to another chain
	function automatic logic [7:0] kw_branch(input logic [7:0] s, input logic [7:0] b);
		logic [7:0] n;
		n = NOEDGE;
		case (s)
			8'd23:  if (b == "N") n = 8'd42;
			8'd42:  if (b == "C") n = 8'd44;
			8'd22:  if (b == "O") n = 8'd46;
			8'd27:  if (b == "L") n = 8'd56;
			8'd30: begin
				if (b == "A") n = 8'd48;
				if (b == "I") n = 8'd51;
			end
			8'd76: begin
				if (b == "P") n = 8'd77;
				if (b == "S") n = 8'd82;
				if (b == "J") n = 8'd86;
			end
			8'd109: if (b == "B") n = 8'd110;
			8'd113: begin
				if (b == "L") n = 8'd117;
				if (b == "O") n = 8'd124;
				if (b == "U") n = 8'd137;
				if (b == "R") n = 8'd140;
			end
			8'd126: begin
				if (b == "G") n = 8'd127;
				if (b == "L") n = 8'd130;
			end
			8'd124: if (b == "I") n = 8'd134;
			8'd150: if (b == "S") n = 8'd154;
			8'd149: if (b == "E") n = 8'd157;
			8'd157: if (b == "T") n = 8'd164;
			8'd169: if (b == "R") n = 8'd175;
			8'd168: begin
				if (b == "U") n = 8'd178;
				if (b == "H") n = 8'd184;
				if (b == "P") n = 8'd188;
			end
			8'd212: if (b == "E") n = 8'd219;
			default: n = NOEDGE;
		endcase
		return n;
	endfunction

	function automatic logic first_letter(input logic [7:0] s);
		case (s)
			8'd19, 8'd22, 8'd27, 8'd30, 8'd63, 8'd70, 8'd75, 8'd93,
			8'd97, 8'd107, 8'd113, 8'd149, 8'd168, 8'd195, 8'd201, 8'd212: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic is_upper(input logic [7:0] b);
		return (b >= "A") && (b <= "Z");
	endfunction

	function automatic logic is_lower(input logic [7:0] b);
		return (b >= "a") && (b <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
	endfunction

	function automatic logic [7:0] dfa_next(input logic [7:0] s, input logic [7:0] b);
		logic [7:0] n;
		logic [7:0] cl;
		n = NOEDGE;
		cl = chain_letter(s);
		case (s)
			8'd0: begin
				case (b)
					"F": n = 8'd19;   "B": n = 8'd22;   "E": n = 8'd27;   "C": n = 8'd30;
					"D": n = 8'd63;   "H": n = 8'd70;   "I": n = 8'd75;   "L": n = 8'd93;
					"M": n = 8'd97;   "O": n = 8'd107;  "P": n = 8'd113;  "R": n = 8'd149;
					"S": n = 8'd168;  "T": n = 8'd195;  "U": n = 8'd201;  "W": n = 8'd212;
					"#": n = 8'd2;    "\\": n = 8'd6;   "-": n = 8'd8;    "/": n = 8'd10;
					"&": n = 8'd11;   "|": n = 8'd12;   "(": n = 8'd13;   ")": n = 8'd14;
					";": n = 8'd15;   ":": n = 8'd16;   "*": n = 8'd18;   " ": n = 8'd37;
					8'h0A: n = 8'd38; 8'h09: n = 8'd39; 8'h0D: n = 8'd40; "+": n = 8'd41;
					",": n = 8'd222;  "{": n = 8'd223;  "}": n = 8'd224;  "[": n = 8'd225;
					"]": n = 8'd226;
					default: begin
						if (is_upper(b) || is_lower(b))
							n = 8'd4;
						else if (is_digit(b))
							n = 8'd1;
					end
				endcase
			end
			8'd1: if (is_digit(b)) n = 8'd1;
			8'd2: begin
				if (b == "#")
					n = 8'd2;
				else if (is_hex(b))
					n = 8'd3;
			end
			8'd3: if (is_hex(b)) n = 8'd3;
			8'd4: begin
				if (is_upper(b) || is_lower(b))
					n = 8'd4;
				else if (is_digit(b))
					n = 8'd5;
			end
			8'd5: if (is_digit(b)) n = 8'd5;
			8'd6: begin
				if (b == "+") n = 8'd7;
				if (b == "*") n = 8'd9;
			end
			8'd7:  if (b == "+") n = 8'd7;
			8'd9:  if (b == "*") n = 8'd9;
			8'd16: if (b == "=") n = 8'd17;
			8'd17: if (b == "=") n = 8'd17;
			default: begin
				if ((cl != 8'd0) && (b == cl))
					n = s + 8'd1;
				else
					n = kw_branch(s, b);
				if ((n == NOEDGE) && first_letter(s) && is_upper(b))
					n = 8'd4;
			end
		endcase
		return n;
	endfunction

	function automatic logic [6:0] dfa_kind(input logic [7:0] s);
		logic [6:0] k;
		case (s)
			8'd0, 8'd2, 8'd6: k = KIND_ERROR;
			8'd1: k = 7'd1;    8'd3: k = 7'd2;    8'd4: k = 7'd3;    8'd5: k = 7'd4;
			8'd7: k = 7'd5;    8'd9: k = 7'd6;    8'd8: k = 7'd7;    8'd10: k = 7'd8;
			8'd11: k = 7'd9;   8'd12: k = 7'd10;  8'd13: k = 7'd11;  8'd14: k = 7'd12;
			8'd15: k = 7'd13;  8'd17: k = 7'd14;  8'd18: k = 7'd15;  8'd41: k = 7'd16;
			8'd222: k = 7'd17; 8'd225: k = 7'd18; 8'd226: k = 7'd19; 8'd223: k = 7'd20;
			8'd224: k = 7'd21;
			8'd21: k = 7'd22;  8'd26: k = 7'd23;  8'd29: k = 7'd24;  8'd36: k = 7'd25;
			8'd43: k = 7'd26;  8'd45: k = 7'd27;  8'd47: k = 7'd28;  8'd50: k = 7'd29;
			8'd55: k = 7'd30;  8'd62: k = 7'd31;  8'd69: k = 7'd32;  8'd74: k = 7'd33;
			8'd81: k = 7'd34;  8'd85: k = 7'd35;  8'd92: k = 7'd36;  8'd96: k = 7'd37;
			8'd106: k = 7'd38; 8'd109: k = 7'd39; 8'd112: k = 7'd40; 8'd116: k = 7'd41;
			8'd123: k = 7'd42; 8'd129: k = 7'd43; 8'd133: k = 7'd44; 8'd136: k = 7'd45;
			8'd139: k = 7'd46; 8'd148: k = 7'd47; 8'd153: k = 7'd48; 8'd156: k = 7'd49;
			8'd163: k = 7'd50; 8'd167: k = 7'd51; 8'd174: k = 7'd52; 8'd177: k = 7'd53;
			8'd183: k = 7'd54; 8'd187: k = 7'd55; 8'd194: k = 7'd56; 8'd200: k = 7'd57;
			8'd211: k = 7'd58; 8'd218: k = 7'd59; 8'd221: k = 7'd60;
			default: k = KIND_IGN;
		endcase
		return k;
	endfunction

endpackage

### sv/dlx_in_if.sv
// Character channel of the DFA keyword lexer: valid/ready plus one source byte or end mark.
// No dependencies.
`timescale 1ns / 1ps

interface dlx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_mark;

	modport source (output valid, char_byte, end_mark, input ready);
	modport sink   (input valid, char_byte, end_mark, output ready);
endinterface

### sv/dlx_out_if.sv
// Token channel of the DFA keyword lexer: valid/ready plus one token result.
// No dependencies.
`timescale 1ns / 1ps

interface dlx_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  token_kind;
	logic [15:0] start_row;
	logic [15:0] start_column;
	logic [7:0]  token_length;
	logic        at_input_end;
	logic        item_done;

	modport source (output valid, token_kind, start_row, start_column, token_length,
		at_input_end, item_done, input ready);
	modport sink   (input valid, token_kind, start_row, start_column, token_length,
		at_input_end, item_done, output ready);
endinterface

### sv/dfa_keyword_lexer.sv
// Top level of the DFA keyword lexer: transition logic, position counters, token queue.
// Depends on dlx_pkg, dlx_in_if, dlx_out_if and dfa_keyword_lexer_assert.svh.
`timescale 1ns / 1ps
// Usage
//   chars  : one item per source byte (char_byte) or an end mark (end_mark = 1).
//   tokens : token items - kind, start row/column, length, at_input_end, item_done.
//   An item causes zero, one or two tokens; item_done marks the last token of an item.
// Ordering: a token caused by an item is written into the token queue registers when
//   that item is taken and is offered on tokens behind any tokens already queued.
// Throughput: one item per cycle while chars.ready is high. The DFA step, kind
//   lookup and position update for an item are table lookups and a few compares on
//   the state registers, done in the cycle the item is taken.
//   The token side drains one token per cycle while tokens.ready is high, through
//   a four-entry queue; chars.ready stays high while at least two entries are free,
//   so a stalled receiver fills the queue, then holds off the sender; no token is lost.
// Reset: the DFA returns to the start state, positions to row 1 column 1,
//   the error halt clears and the token queue empties. No clearing pass.
// After a lexical error every byte is dropped until the end mark, which restarts
//   the lexer with positions back at row 1 column 1.

`include "dfa_keyword_lexer_assert.svh"

module dfa_keyword_lexer
	import dlx_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	dlx_in_if.sink          chars,
	dlx_out_if.source       tokens
);

	// lexer state
	logic [7:0]  state_q, state_d;
	logic [7:0]  plen_q, plen_d;
	logic [15:0] trow_q, trow_d;
	logic [15:0] tcol_q, tcol_d;
	logic [15:0] line_q, line_d;
	logic [15:0] col_q, col_d;
	logic        halt_q, halt_d;

	// token queue
	res_t        fifo_q [4];
	logic [1:0]  rd_ptr_q;
	logic [1:0]  wr_ptr_q;
	logic [2:0]  cnt_q;

	logic        acc;
	logic        pop;
	logic [7:0]  b;
	logic [7:0]  nx;
	logic [7:0]  nx0;
	logic [6:0]  kind;
	res_t        r0, r1;
	logic [1:0]  n_res;
	logic        take_en;
	logic        take_fresh;
	logic [7:0]  take_nx;
	res_t        err_res;

	assign acc = chars.valid && chars.ready;
	assign pop = tokens.valid && tokens.ready;
	assign b   = chars.char_byte;
	assign nx  = dfa_next(state_q, b);
	assign nx0 = dfa_next(START_STATE, b);
	assign kind = dfa_kind(state_q);

	// room for the worst case of two tokens per item
	assign chars.ready = (cnt_q <= 3'd2);

	always_comb begin
		state_d    = state_q;
		plen_d     = plen_q;
		trow_d     = trow_q;
		tcol_d     = tcol_q;
		line_d     = line_q;
		col_d      = col_q;
		halt_d     = halt_q;
		r0         = '0;
		r1         = '0;
		n_res      = 2'd0;
		take_en    = 1'b0;
		take_fresh = 1'b0;
		take_nx    = nx;
		// error at the current position, used when the byte is not taken at all
		err_res    = '{kind: KIND_ERROR, row: line_q, col: col_q, len: 8'd0,
			at_end: 1'b0, done: 1'b1};

		if (chars.end_mark) begin
			if (!halt_q && (state_q != START_STATE)) begin
				if (kind == KIND_ERROR) begin
					r0 = '{kind: KIND_ERROR, row: trow_q, col: tcol_q, len: 8'd0,
						at_end: 1'b1, done: 1'b1};
					n_res = 2'd1;
				end else if (kind != KIND_IGN) begin
					r0 = '{kind: kind, row: trow_q, col: tcol_q, len: plen_q,
						at_end: 1'b1, done: 1'b1};
					n_res = 2'd1;
				end
			end
			state_d = START_STATE;
			plen_d  = 8'd0;
			trow_d  = 16'd1;
			tcol_d  = 16'd1;
			line_d  = 16'd1;
			col_d   = 16'd1;
			halt_d  = 1'b0;
		end else if (!halt_q) begin
			if (nx != NOEDGE) begin
				take_en    = 1'b1;
				take_fresh = (state_q == START_STATE);
				take_nx    = nx;
			end else if ((state_q != START_STATE) && (kind == KIND_ERROR)) begin
				// dead partial token: error at its start, byte dropped
				r0 = '{kind: KIND_ERROR, row: trow_q, col: tcol_q, len: 8'd0,
					at_end: 1'b0, done: 1'b1};
				n_res   = 2'd1;
				halt_d  = 1'b1;
				state_d = START_STATE;
			end else begin
				state_d = START_STATE;
				plen_d  = 8'd0;
				if ((state_q != START_STATE) && (kind != KIND_IGN)) begin
					r0 = '{kind: kind, row: trow_q, col: tcol_q, len: plen_q,
						at_end: 1'b0, done: 1'b0};
					n_res = 2'd1;
				end
				if ((state_q != START_STATE) && (nx0 != NOEDGE)) begin
					// same byte restarts from the start state
					take_en    = 1'b1;
					take_fresh = 1'b1;
					take_nx    = nx0;
					r0.done    = 1'b1;
				end else begin
					if (n_res == 2'd0)
						r0 = err_res;
					else
						r1 = err_res;
					n_res  = n_res + 2'd1;
					halt_d = 1'b1;
				end
			end
		end

		if (take_en) begin
			state_d = take_nx;
			if (take_fresh) begin
				trow_d = line_q;
				tcol_d = col_q;
				plen_d = 8'd1;
			end else if (plen_q < LEN_LIM) begin
				plen_d = plen_q + 8'd1;
			end
			if (b == CHAR_NL) begin
				if (line_q < POS_LIM)
					line_d = line_q + 16'd1;
				col_d = 16'd1;
			end else if (col_q < POS_LIM) begin
				col_d = col_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= START_STATE;
			plen_q   <= 8'd0;
			trow_q   <= 16'd1;
			tcol_q   <= 16'd1;
			line_q   <= 16'd1;
			col_q    <= 16'd1;
			halt_q   <= 1'b0;
			rd_ptr_q <= 2'd0;
			wr_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (acc) begin
				state_q  <= state_d;
				plen_q   <= plen_d;
				trow_q   <= trow_d;
				tcol_q   <= tcol_d;
				line_q   <= line_d;
				col_q    <= col_d;
				halt_q   <= halt_d;
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + (acc ? {1'b0, n_res} : 3'd0) - {2'b0, pop};
		end
	end

	// queue payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc && (n_res != 2'd0))
			fifo_q[wr_ptr_q] <= r0;
		if (acc && (n_res == 2'd2))
			fifo_q[wr_ptr_q + 2'd1] <= r1;
	end

	assign tokens.valid        = (cnt_q != 3'd0);
	assign tokens.token_kind   = fifo_q[rd_ptr_q].kind;
	assign tokens.start_row    = fifo_q[rd_ptr_q].row;
	assign tokens.start_column = fifo_q[rd_ptr_q].col;
	assign tokens.token_length = fifo_q[rd_ptr_q].len;
	assign tokens.at_input_end = fifo_q[rd_ptr_q].at_end;
	assign tokens.item_done    = fifo_q[rd_ptr_q].done;

	`DLX_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= 3'd4)
	`DLX_ASSERT_IMP(a_halt_quiet, clk, arst_n, acc && !chars.end_mark && halt_q, n_res == 2'd0)
	`DLX_ASSERT_NXT(a_error_halts, clk, arst_n,
		acc && !chars.end_mark && halt_d && !halt_q, halt_q && (state_q == START_STATE))
	`DLX_ASSERT_IMP(a_two_ends_err, clk, arst_n, acc && (n_res == 2'd2),
		(r1.kind == KIND_ERROR) && r1.done && !r0.done)

endmodule

### dv/dfa_keyword_lexer_tb.sv
// Self-checking bench for the DFA keyword lexer: directed rows, then random source text.
// Depends on dlx_pkg, dlx_in_if, dlx_out_if and the dfa_keyword_lexer top level.
`timescale 1ns / 1ps

module dfa_keyword_lexer_tb;
	import dlx_pkg::*;

	localparam int N_RANDOM = 280;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BSL = 8'h5C;

	typedef struct packed {
		logic [6:0]  kind;
		logic [15:0] row;
		logic [15:0] col;
		logic [7:0]  len;
		logic        at_end;
		logic        done;
	} tok_t;

	// one directed row: byte, end mark, and an optional typed-in expectation
	typedef struct {
		logic [7:0] ch;
		logic       em;
		bit         typed;
		tok_t       tok;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	dlx_in_if chars ();
	dlx_out_if tokens ();

	dfa_keyword_lexer dut (.clk(clk), .arst_n(arst_n), .chars(chars), .tokens(tokens));

	// predictor state
	logic [7:0]  lx_state;
	logic [7:0]  lx_len;
	logic [15:0] lx_trow, lx_tcol, lx_line, lx_col;
	logic        lx_halt;

	// edge and kind tables, built from the word list
	logic [7:0] nxt_tab [0:226][0:255];
	logic [6:0] kind_tab [0:226];

	tok_t tok_q[$];
	tok_t typed_q[$];
	int   n_fail = 0;
	int   n_tok = 0;
	int   n_items = 0;
	int   n_err = 0;
	int   n_kw = 0;
	longint cyc = 0;
	bit   quiet = 1'b0;
	bit   drain_hold = 1'b0;
	bit   long_hold = 1'b0;

	task automatic put_word(input int from, input string w, input int first);
		int s, n;
		s = from;
		n = first;
		for (int i = 0; i < w.len(); i++) begin
			nxt_tab[s][w[i]] = n[7:0];
			s = n;
			n++;
		end
	endtask

	task automatic span_to(input int s, input int lo, input int hi, input int to);
		for (int c = lo; c <= hi; c++)
			nxt_tab[s][c] = to[7:0];
	endtask

	task automatic build_lexer_tables();
		int kw_ends[39] = '{21, 26, 29, 36, 43, 45, 47, 50, 55, 62, 69, 74, 81, 85, 92, 96,
			106, 109, 112, 116, 123, 129, 133, 136, 139, 148, 153, 156, 163, 167, 174, 177,
			183, 187, 194, 200, 211, 218, 221};
		int firsts[16] = '{19, 22, 27, 30, 63, 70, 75, 93, 97, 107, 113, 149, 168, 195,
			201, 212};
		for (int s = 0; s < 227; s++) begin
			kind_tab[s] = KIND_IGN;
			for (int c = 0; c < 256; c++)
				nxt_tab[s][c] = NOEDGE;
		end
		put_word(0, "FOR", 19);
		put_word(0, "BEGIN", 22); put_word(23, "ND", 42); put_word(42, "CH", 44);
		put_word(22, "OX", 46);
		put_word(0, "END", 27); put_word(27, "LEVATOR", 56);
		put_word(0, "CONSOLE", 30); put_word(30, "ALL", 48); put_word(30, "IRCLE", 51);
		put_word(0, "DEEPSEA", 63);
		put_word(0, "HUMAN", 70);
		put_word(0, "IN", 75); put_word(76, "PLACE", 77); put_word(76, "SITU", 82);
		put_word(76, "JECTION", 86);
		put_word(0, "LINE", 93);
		put_word(0, "MONITORING", 97);
		put_word(0, "ORE", 107); put_word(109, "BED", 110);
		put_word(0, "P", 113); put_word(113, "ATH", 114); put_word(113, "LATFORM", 117);
		put_word(113, "OLY", 124); put_word(126, "GON", 127); put_word(126, "LINE", 130);
		put_word(124, "INT", 134); put_word(113, "UMP", 137);
		put_word(113, "ROCESSING", 140);
		put_word(0, "RIVER", 149); put_word(150, "SER", 154); put_word(149, "ECOVERY", 157);
		put_word(157, "TURN", 164);
		put_word(0, "STORAGE", 168); put_word(169, "RIP", 175); put_word(168, "URFACE", 178);
		put_word(168, "HAFT", 184); put_word(168, "POILPIT", 188);
		put_word(0, "TUNNEL", 195);
		put_word(0, "UNDERGROUND", 201);
		put_word(0, "WASHING", 212); put_word(212, "ELL", 219);
		// single-letter prefixes fall through to identifiers on other capitals
		foreach (firsts[i])
			for (int c = "A"; c <= "Z"; c++)
				if (nxt_tab[firsts[i]][c] == NOEDGE)
					nxt_tab[firsts[i]][c] = 8'd4;
		nxt_tab[0][CH_HASH] = 8'd2; nxt_tab[2][CH_HASH] = 8'd2;
		for (int c = 0; c < 256; c++)
			if (nxt_tab[0][c] == NOEDGE && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")))
				nxt_tab[0][c] = 8'd4;
		span_to(4, "A", "Z", 4); span_to(4, "a", "z", 4);
		span_to(0, "0", "9", 1); span_to(1, "0", "9", 1);
		span_to(2, "0", "9", 3); span_to(3, "0", "9", 3);
		span_to(4, "0", "9", 5); span_to(5, "0", "9", 5);
		span_to(2, "a", "f", 3); span_to(3, "a", "f", 3);
		span_to(2, "A", "F", 3); span_to(3, "A", "F", 3);
		nxt_tab[0][CH_BSL] = 8'd6;
		nxt_tab[6]["+"] = 8'd7; nxt_tab[7]["+"] = 8'd7;
		nxt_tab[6]["*"] = 8'd9; nxt_tab[9]["*"] = 8'd9;
		nxt_tab[0]["-"] = 8'd8; nxt_tab[0]["/"] = 8'd10; nxt_tab[0]["&"] = 8'd11;
		nxt_tab[0]["|"] = 8'd12; nxt_tab[0]["("] = 8'd13; nxt_tab[0][")"] = 8'd14;
		nxt_tab[0][";"] = 8'd15; nxt_tab[0][":"] = 8'd16;
		nxt_tab[16]["="] = 8'd17; nxt_tab[17]["="] = 8'd17; nxt_tab[0]["*"] = 8'd18;
		nxt_tab[0][" "] = 8'd37; nxt_tab[0][8'h0A] = 8'd38; nxt_tab[0][8'h09] = 8'd39;
		nxt_tab[0][8'h0D] = 8'd40; nxt_tab[0]["+"] = 8'd41;
		nxt_tab[0][","] = 8'd222; nxt_tab[0]["{"] = 8'd223; nxt_tab[0]["}"] = 8'd224;
		nxt_tab[0]["["] = 8'd225; nxt_tab[0]["]"] = 8'd226;
		kind_tab[0] = KIND_ERROR; kind_tab[2] = KIND_ERROR; kind_tab[6] = KIND_ERROR;
		kind_tab[1] = 7'd1; kind_tab[3] = 7'd2; kind_tab[4] = 7'd3; kind_tab[5] = 7'd4;
		kind_tab[7] = 7'd5; kind_tab[9] = 7'd6; kind_tab[8] = 7'd7; kind_tab[10] = 7'd8;
		kind_tab[11] = 7'd9; kind_tab[12] = 7'd10; kind_tab[13] = 7'd11;
		kind_tab[14] = 7'd12; kind_tab[15] = 7'd13; kind_tab[17] = 7'd14;
		kind_tab[18] = 7'd15; kind_tab[41] = 7'd16; kind_tab[222] = 7'd17;
		kind_tab[225] = 7'd18; kind_tab[226] = 7'd19; kind_tab[223] = 7'd20;
		kind_tab[224] = 7'd21;
		foreach (kw_ends[i])
			kind_tab[kw_ends[i]] = 7'(22 + i);
	endtask

	task automatic lexer_restart();
		lx_state = START_STATE;
		lx_len = 8'd0;
		lx_trow = 16'd1; lx_tcol = 16'd1;
		lx_line = 16'd1; lx_col = 16'd1;
		lx_halt = 1'b0;
	endtask

	task automatic consume_byte(input logic [7:0] nx, input logic [7:0] b);
		if (lx_state == START_STATE) begin
			lx_trow = lx_line;
			lx_tcol = lx_col;
			lx_len = 8'd0;
		end
		lx_state = nx;
		if (lx_len < LEN_LIM)
			lx_len++;
		if (b == CHAR_NL) begin
			if (lx_line < POS_LIM)
				lx_line++;
			lx_col = 16'd1;
		end else if (lx_col < POS_LIM)
			lx_col++;
	endtask

	function automatic tok_t mk_tok(input logic [6:0] k, input logic [15:0] r,
		input logic [15:0] c, input logic [7:0] l, input logic e);
		tok_t t;
		t = '{kind: k, row: r, col: c, len: l, at_end: e, done: 1'b0};
		return t;
	endfunction

	// Predict the tokens of one character item and queue them.
	task automatic predict_tokens(input logic [7:0] b, input logic em);
		tok_t out[$];
		logic [7:0] nx;
		logic [6:0] k;
		if (em) begin
			if (!lx_halt && lx_state != START_STATE) begin
				k = kind_tab[lx_state];
				if (k == KIND_ERROR)
					out.push_back(mk_tok(KIND_ERROR, lx_trow, lx_tcol, 8'd0, 1'b1));
				else if (k != KIND_IGN)
					out.push_back(mk_tok(k, lx_trow, lx_tcol, lx_len, 1'b1));
			end
			lexer_restart();
		end else if (!lx_halt) begin
			nx = nxt_tab[lx_state][b];
			if (nx != NOEDGE)
				consume_byte(nx, b);
			else begin
				if (lx_state != START_STATE) begin
					k = kind_tab[lx_state];
					lx_state = START_STATE;
					if (k == KIND_ERROR) begin
						// dead '#' or backslash: error at token start, byte dropped
						out.push_back(mk_tok(KIND_ERROR, lx_trow, lx_tcol, 8'd0, 1'b0));
						lx_halt = 1'b1;
					end else begin
						if (k != KIND_IGN)
							out.push_back(mk_tok(k, lx_trow, lx_tcol, lx_len, 1'b0));
						lx_len = 8'd0;
						nx = nxt_tab[0][b];
						if (nx != NOEDGE)
							consume_byte(nx, b);
					end
				end
				if (!lx_halt && lx_state == START_STATE) begin
					out.push_back(mk_tok(KIND_ERROR, lx_line, lx_col, 8'd0, 1'b0));
					lx_halt = 1'b1;
				end
			end
		end
		if (out.size() > 0)
			out[out.size() - 1].done = 1'b1;
		foreach (out[i]) begin
			tok_q.push_back(out[i]);
			if (out[i].kind == KIND_ERROR)
				n_err++;
			else if (out[i].kind >= 7'd22)
				n_kw++;
		end
	endtask

	// sender; valid stays up after an accept so items can follow back to back
	task automatic send_char(input logic [7:0] b, input logic em);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			chars.valid <= 1'b0;
			@(posedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_byte <= b;
		chars.end_mark <= em;
		@(posedge clk);
		while (!chars.ready)
			@(posedge clk);
		predict_tokens(b, em);
		n_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic wait_drained();
		chars.valid <= 1'b0;
		while (tok_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going
	always @(posedge clk) begin
		if (!arst_n)
			tokens.ready <= 1'b0;
		else if (long_hold)
			tokens.ready <= 1'b0;
		else
			tokens.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
	end

	initial begin
		wait (n_items >= 450);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (60) @(posedge clk);
		long_hold = 1'b0;
	end

	// checker
	always @(posedge clk) begin
		tok_t got, exp_t;
		if (arst_n && tokens.valid && tokens.ready) begin
			got = '{kind: tokens.token_kind, row: tokens.start_row, col: tokens.start_column,
				len: tokens.token_length, at_end: tokens.at_input_end,
				done: tokens.item_done};
			n_tok++;
			if (tok_q.size() == 0) begin
				$display("%0t: unexpected token, expected none, actual %p", $realtime, got);
				n_fail++;
			end else begin
				exp_t = tok_q.pop_front();
				if (got !== exp_t) begin
					$display("%0t: token mismatch, expected %p, actual %p",
						$realtime, exp_t, got);
					n_fail++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("[dfa_keyword_lexer] ERROR");
			$finish;
		end
	end

	function automatic row_t rw(input logic [7:0] c, input logic e);
		row_t r;
		r = '{ch: c, em: e, typed: 1'b0, tok: '0};
		return r;
	endfunction

	function automatic row_t rwt(input logic [7:0] c, input logic e, input tok_t t);
		row_t r;
		r = '{ch: c, em: e, typed: 1'b1, tok: t};
		return r;
	endfunction

	// random source text: mostly well-formed words, some noise
	task automatic send_random_token();
		string kws[39] = '{"FOR", "BEGIN", "END", "CONSOLE", "BEND", "BENCH", "BOX",
			"CALL", "CIRCLE", "ELEVATOR", "DEEPSEA", "HUMAN", "INPLACE", "INSITU",
			"INJECTION", "LINE", "MONITORING", "ORE", "OREBED", "PATH", "PLATFORM",
			"POLYGON", "POLYLINE", "POINT", "PUMP", "PROCESSING", "RIVER", "RISER",
			"RECOVERY", "RETURN", "STORAGE", "STRIP", "SURFACE", "SHAFT", "SPOILPIT",
			"TUNNEL", "UNDERGROUND", "WASHING", "WELL"};
		string ops = "-/&|();*+,[]{}";
		string ws = " \n\t\r";
		string hx = "0123456789abcdefABCDEF";
		int sel, n;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			send_text(kws[$urandom_range(0, 38)]);
			if ($urandom_range(0, 3) == 0)
				send_text(kws[$urandom_range(0, 38)].substr(0, 0));
		end else if (sel < 40) begin
			n = $urandom_range(1, 6);
			repeat (n) send_char($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
				: 8'($urandom_range("A", "Z")), 1'b0);
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3))
					send_char(8'($urandom_range("0", "9")), 1'b0);
		end else if (sel < 48) begin
			repeat ($urandom_range(1, 5)) send_char(8'($urandom_range("0", "9")), 1'b0);
		end else if (sel < 54) begin
			repeat ($urandom_range(1, 2)) send_char(CH_HASH, 1'b0);
			repeat ($urandom_range(1, 4)) send_char(hx[$urandom_range(0, 21)], 1'b0);
		end else if (sel < 58) begin
			send_char(CH_BSL, 1'b0);
			repeat ($urandom_range(1, 3)) send_char($urandom_range(0, 1) ? "+" : "*", 1'b0);
		end else if (sel < 61) begin
			send_char(":", 1'b0);
			repeat ($urandom_range(0, 3)) send_char("=", 1'b0);
		end else if (sel < 72) begin
			send_char(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
		end else if (sel < 90) begin
			send_char(ws[$urandom_range(0, 3)], 1'b0);
		end else if (sel < 96) begin
			send_char(8'($urandom_range(0, 255)), 1'b0);
		end else
			send_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		row_t rows[$];
		build_lexer_tables();
		lexer_restart();
		chars.valid = 1'b0;
		chars.char_byte = 8'd0;
		chars.end_mark = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed-in tokens are cross-checked against the predictor
		rows.push_back(rwt(8'h00, 1'b0, mk_tok(KIND_ERROR, 16'd1, 16'd1, 8'd0, 1'b0)));
		rows.push_back(rw(8'hFF, 1'b1));              // halted: end mark only restarts
		rows.push_back(rw("B", 1'b0)); rows.push_back(rw("O", 1'b0));
		rows.push_back(rw("X", 1'b0));
		rows.push_back(rwt(8'hFF, 1'b1, mk_tok(7'd28, 16'd1, 16'd1, 8'd3, 1'b1)));
		rows.push_back(rw("B", 1'b0)); rows.push_back(rw("E", 1'b0));
		rows.push_back(rw(8'h0A, 1'b0));              // dropped keyword prefix
		rows.push_back(rw(CH_HASH, 1'b0));
		rows.push_back(rwt("g", 1'b0, mk_tok(KIND_ERROR, 16'd2, 16'd1, 8'd0, 1'b0)));
		rows.push_back(rw(8'h00, 1'b1));
		rows.push_back(rw(CH_BSL, 1'b0));
		rows.push_back(rwt(8'h00, 1'b1, mk_tok(KIND_ERROR, 16'd1, 16'd1, 8'd0, 1'b1)));
		rows.push_back(rw("F", 1'b0)); rows.push_back(rw("Q", 1'b0));
		rows.push_back(rw("7", 1'b0)); rows.push_back(rw(":", 1'b0));
		rows.push_back(rw(" ", 1'b0)); rows.push_back(rw("~", 1'b0));
		rows.push_back(rw(8'h80, 1'b1));
		foreach (rows[i]) begin
			if (rows[i].typed)
				typed_q.push_back(rows[i].tok);
			send_char(rows[i].ch, rows[i].em);
			if (rows[i].typed) begin
				if (tok_q.size() == 0 || tok_q[tok_q.size() - 1].kind != typed_q[0].kind
					|| tok_q[tok_q.size() - 1].len != typed_q[0].len) begin
					$display("%0t: directed row %0d, expected %p, actual %p", $realtime, i,
						typed_q[0], tok_q.size() ? tok_q[tok_q.size() - 1] : tok_t'(0));
					n_fail++;
				end
				void'(typed_q.pop_front());
			end
		end
		// long identifier: length saturates
		repeat (260) send_char("a", 1'b0);
		send_char(8'h00, 1'b1);
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 100 && i < 150);
			send_random_token();
			if (i == 200)
				wait_drained();             // sender pauses until all tokens are in
		end
		quiet = 1'b0;
		send_char(8'h00, 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d items and %0d tokens (%0d keywords, %0d lexical errors).",
			n_items, n_tok, n_kw, n_err);
		if (n_fail == 0 && tok_q.size() == 0)
			$display("[dfa_keyword_lexer] OK");
		else
			$display("[dfa_keyword_lexer] ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/dlx_pkg.sv
sv/dlx_in_if.sv
sv/dlx_out_if.sv
sv/dfa_keyword_lexer.sv
dv/dfa_keyword_lexer_tb.sv
